>>> design/cpet_pkg.sv
// ----------------------------------------------------------------------------
// cpet_pkg
// Types and constants shared by the collision pair event tracker.
// ----------------------------------------------------------------------------
`default_nettype none
package cpet_pkg;

	localparam int MAX_COLLIDERS_DEF = 64;
	localparam int ID_W   = 6;
	localparam int POS_W  = 20;
	localparam int SIZE_W = 16;

	localparam logic SHAPE_RECT   = 1'b0;
	localparam logic SHAPE_CIRCLE = 1'b1;

	typedef enum logic [1:0] {
		EV_NONE  = 2'd0,
		EV_ENTER = 2'd1,
		EV_STAY  = 2'd2,
		EV_EXIT  = 2'd3
	} event_t;

	typedef struct packed {
		logic [ID_W-1:0]          first_id;
		logic [ID_W-1:0]          second_id;
		logic                     first_shape;
		logic                     second_shape;
		logic signed [POS_W-1:0]  first_pos_x;
		logic signed [POS_W-1:0]  first_pos_y;
		logic signed [POS_W-1:0]  second_pos_x;
		logic signed [POS_W-1:0]  second_pos_y;
		logic [SIZE_W-1:0]        first_size_w;
		logic [SIZE_W-1:0]        first_size_h;
		logic [SIZE_W-1:0]        second_size_w;
		logic [SIZE_W-1:0]        second_size_h;
	} pair_t;

	typedef struct packed {
		logic [1:0]      event_res;
		logic [ID_W-1:0] event_first_id;
		logic [ID_W-1:0] event_second_id;
	} result_t;

	typedef enum logic [2:0] {
		ST_CLR,
		ST_IDLE,
		ST_CALC,
		ST_MUL,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic clr;
		logic load;
		logic calc;
		logic mul;
		logic done;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
	} status_t;

endpackage
`default_nettype wire

>>> design/cpet_ctrl.sv
// ----------------------------------------------------------------------------
// cpet_ctrl
// Sequencer: table clear after reset, then load, calc, multiply, finish.
// ----------------------------------------------------------------------------
`default_nettype none
module cpet_ctrl import cpet_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	input  wire status_t sts,
	output logic         busy,
	output cmd_t         cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_CLR;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLR:  if (sts.clr_last) state_d = ST_IDLE;
			ST_IDLE: if (start) state_d = ST_CALC;
			ST_CALC: state_d = ST_MUL;
			ST_MUL:  state_d = ST_DONE;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_CLR;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			ST_CLR:  cmd.clr = 1'b1;
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			ST_CALC: cmd.calc = 1'b1;
			ST_MUL:  cmd.mul  = 1'b1;
			ST_DONE: cmd.done = 1'b1;
			default: cmd = '0;
		endcase
	end

endmodule
`default_nettype wire

>>> design/cpet_dp.sv
// ----------------------------------------------------------------------------
// cpet_dp
// Geometry tests, touching-bit table and result register.
// ----------------------------------------------------------------------------
`default_nettype none
module cpet_dp import cpet_pkg::*; #(
	parameter int MAX_COLLIDERS = MAX_COLLIDERS_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cmd_t  cmd,
	input  wire pair_t pair,
	output status_t    sts,
	output result_t    result,
	output logic       done
);

	localparam int DEPTH = MAX_COLLIDERS * MAX_COLLIDERS;
	localparam int IDXW  = $clog2(DEPTH);
	localparam int DW    = 25;
	localparam int LW    = 24;
	localparam int CW    = 27;
	localparam int SQW   = 2 * CW;

	logic mem [DEPTH];

	pair_t            pair_q;
	logic [IDXW-1:0]  idx_q;
	logic             valid_q;
	logic [IDXW-1:0]  clr_q;
	logic             rd_q;

	logic [DW-1:0]         adx_q, ady_q;
	logic [LW-1:0]         rrw_q, rrh_q, crw_q, crh_q;
	logic signed [CW-1:0]  cx_q, cy_q, r_q;
	logic [SQW-1:0]        sqx_q, sqy_q, sqr_q;
	logic                  rr_hit_q, cr_hit_q;

	logic signed [DW-1:0]  dx, dy;
	logic signed [CW-1:0]  dw50, dh50;
	logic                  hit;
	event_t                ev;

	assign sts.clr_last = (32'(clr_q) == DEPTH - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_q <= '0;
		else if (cmd.clr) clr_q <= clr_q + 1'b1;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pair_q  <= pair;
			idx_q   <= IDXW'(32'(pair.first_id) * MAX_COLLIDERS + 32'(pair.second_id));
			valid_q <= (pair.first_id != pair.second_id)
				&& (32'(pair.first_id) < MAX_COLLIDERS)
				&& (32'(pair.second_id) < MAX_COLLIDERS);
		end
	end

	always_comb begin
		dx   = DW'(($signed({pair_q.first_pos_x[POS_W-1], pair_q.first_pos_x})
			- $signed({pair_q.second_pos_x[POS_W-1], pair_q.second_pos_x}))) <<< 4;
		dy   = DW'(($signed({pair_q.first_pos_y[POS_W-1], pair_q.first_pos_y})
			- $signed({pair_q.second_pos_y[POS_W-1], pair_q.second_pos_y}))) <<< 4;
		dw50 = CW'($signed({1'b0, pair_q.first_size_w}) - $signed({1'b0, pair_q.second_size_w}))
			* CW'(50);
		dh50 = CW'($signed({1'b0, pair_q.first_size_h}) - $signed({1'b0, pair_q.second_size_h}))
			* CW'(50);
	end

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			adx_q <= dx[DW-1] ? DW'(-dx) : DW'(dx);
			ady_q <= dy[DW-1] ? DW'(-dy) : DW'(dy);
			rrw_q <= LW'(pair_q.first_size_w + LW'(pair_q.second_size_w)) * LW'(50);
			rrh_q <= LW'(pair_q.first_size_h + LW'(pair_q.second_size_h)) * LW'(50);
			crw_q <= LW'(pair_q.second_size_w) * LW'(50) + LW'(pair_q.first_size_w) * LW'(100);
			crh_q <= LW'(pair_q.second_size_h) * LW'(50) + LW'(pair_q.first_size_h) * LW'(100);
			cx_q  <= CW'(dx) + dw50;
			cy_q  <= CW'(dy) + dh50;
			r_q   <= CW'(LW'(pair_q.first_size_w + LW'(pair_q.second_size_w)) * LW'(50));
			rd_q  <= mem[idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			sqx_q    <= SQW'(cx_q * cx_q);
			sqy_q    <= SQW'(cy_q * cy_q);
			sqr_q    <= SQW'(r_q * r_q);
			rr_hit_q <= (LW'(adx_q) < rrw_q) && (adx_q[DW-1] == 1'b0)
				&& (LW'(ady_q) < rrh_q) && (ady_q[DW-1] == 1'b0);
			cr_hit_q <= (LW'(adx_q) < crw_q) && (adx_q[DW-1] == 1'b0)
				&& (LW'(ady_q) < crh_q) && (ady_q[DW-1] == 1'b0);
		end
	end

	always_comb begin
		case ({pair_q.first_shape, pair_q.second_shape})
			{SHAPE_RECT, SHAPE_RECT}:     hit = rr_hit_q;
			{SHAPE_CIRCLE, SHAPE_CIRCLE}: hit = ({1'b0, sqx_q} + {1'b0, sqy_q}) <= {1'b0, sqr_q};
			{SHAPE_CIRCLE, SHAPE_RECT}:   hit = cr_hit_q;
			default:                      hit = 1'b0;
		endcase
		if (!valid_q)  ev = EV_NONE;
		else if (hit)  ev = rd_q ? EV_STAY : EV_ENTER;
		else if (rd_q) ev = EV_EXIT;
		else           ev = EV_NONE;
	end

	always_ff @(posedge clk) begin
		if (cmd.clr) mem[clr_q] <= 1'b0;
		else if (cmd.done && valid_q) mem[idx_q] <= hit;
	end

	always_ff @(posedge clk) begin
		if (cmd.done) begin
			result.event_res       <= ev;
			result.event_first_id  <= pair_q.first_id;
			result.event_second_id <= pair_q.second_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else         done <= cmd.done;
	end

endmodule
`default_nettype wire

>>> design/collision_pair_event_tracker.sv
// ----------------------------------------------------------------------------
// collision_pair_event_tracker
// Per-pair collision test with enter/stay/exit tracking.
// ----------------------------------------------------------------------------
// Usage:
//   Drive a pair beat on pair and raise start; it is taken at a rising edge
//   where busy is low. Exactly one result beat follows on result, marked by
//   done for one cycle, once the sequencer has passed its calc, multiply
//   and finish states. A new pair is taken only after the sequencer's load,
//   calc, multiply and finish steps around the touching table are through.
//   A new pair may be accepted while the previous result is on the ports.
//   The receiver cannot stall; done is a one-cycle strobe.
//   Reset: after arst_n releases, the touching table is cleared one entry
//   per cycle, MAX_COLLIDERS*MAX_COLLIDERS cycles (4096 at default), with
//   busy high throughout.
//   Equal ids or ids not below MAX_COLLIDERS give event none, table kept.
// ----------------------------------------------------------------------------
`default_nettype none
module collision_pair_event_tracker import cpet_pkg::*; #(
	parameter int MAX_COLLIDERS = MAX_COLLIDERS_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  start,
	output logic       busy,
	input  wire pair_t pair,
	output result_t    result,
	output logic       done
);

	cmd_t    cmd;
	status_t sts;

	cpet_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.busy   (busy),
		.cmd    (cmd)
	);

	cpet_dp #(.MAX_COLLIDERS(MAX_COLLIDERS)) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.pair   (pair),
		.sts    (sts),
		.result (result),
		.done   (done)
	);

endmodule
`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives pair beats into the collision pair event tracker and checks every
// result beat against an in-bench model of the box, circle and widened-box
// tests and the per-pair touching table.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
	import cpet_pkg::*;

	localparam int NCOL = MAX_COLLIDERS_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PAIR_W = $bits(pair_t);

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	logic    busy;
	pair_t   pair = '0;
	result_t result;
	logic    done;

	collision_pair_event_tracker dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.pair(pair), .result(result), .done(done)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	pair_t   pending_pairs[$];
	result_t expected_events[$];
	bit      touching[NCOL*NCOL];
	int      mismatches = 0;
	int      cycles = 0;
	bit      no_gaps = 1'b0;
	bit      hold_until_drained = 1'b0;
	int      gap_left = 0;
	bit      stim_done = 1'b0;

	function automatic bit pair_overlaps(pair_t p);
		longint dx, dy, w1, h1, w2, h2, cx, cy, r, adx, ady;
		dx = 16 * (longint'($signed(p.first_pos_x)) - longint'($signed(p.second_pos_x)));
		dy = 16 * (longint'($signed(p.first_pos_y)) - longint'($signed(p.second_pos_y)));
		w1 = longint'(p.first_size_w);
		h1 = longint'(p.first_size_h);
		w2 = longint'(p.second_size_w);
		h2 = longint'(p.second_size_h);
		adx = dx < 0 ? -dx : dx;
		ady = dy < 0 ? -dy : dy;
		if (p.first_shape == SHAPE_RECT && p.second_shape == SHAPE_RECT)
			return adx < 50 * (w1 + w2) && ady < 50 * (h1 + h2);
		if (p.first_shape == SHAPE_CIRCLE && p.second_shape == SHAPE_CIRCLE) begin
			cx = dx + 50 * (w1 - w2);
			cy = dy + 50 * (h1 - h2);
			r = 50 * (w1 + w2);
			return cx * cx + cy * cy <= r * r;
		end
		if (p.first_shape == SHAPE_CIRCLE)
			return adx < 50 * w2 + 100 * w1 && ady < 50 * h2 + 100 * h1;
		return 1'b0;
	endfunction

	function automatic result_t track_pair(pair_t p);
		result_t r;
		int idx;
		bit hit;
		r.event_res = EV_NONE;
		r.event_first_id = p.first_id;
		r.event_second_id = p.second_id;
		if (p.first_id != p.second_id && p.first_id < NCOL && p.second_id < NCOL) begin
			idx = p.first_id * NCOL + p.second_id;
			hit = pair_overlaps(p);
			if (hit) begin
				r.event_res = touching[idx] ? EV_STAY : EV_ENTER;
				touching[idx] = 1'b1;
			end else if (touching[idx]) begin
				r.event_res = EV_EXIT;
				touching[idx] = 1'b0;
			end
		end
		return r;
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				expected_events.push_back(track_pair(pair));
				void'(pending_pairs.pop_front());
			end
			if (start && busy) begin
				// beat still waiting
			end else if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				start <= 1'b0;
			end else if (hold_until_drained && (expected_events.size() != 0 ||
					(start && !busy))) begin
				start <= 1'b0;
			end else if (!no_gaps && $urandom_range(0, 9) == 0 && !(start && !busy)) begin
				gap_left <= $urandom_range(1, 7) - 1;
				start <= 1'b0;
			end else if (pending_pairs.size() > ((start && !busy) ? 0 : 0) &&
					!(start && !busy && pending_pairs.size() == 0)) begin
				hold_until_drained <= 1'b0;
				start <= pending_pairs.size() != 0;
				if (pending_pairs.size() != 0) pair <= pending_pairs[0];
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && done) begin
			if (expected_events.size() == 0) begin
				mismatches <= mismatches + 1;
				if (mismatches < 10)
					$display("unexpected result beat %p", result);
			end else begin
				if (result !== expected_events[0]) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("mismatch: expected %p got %p", expected_events[0], result);
				end
				void'(expected_events.pop_front());
			end
		end
		if (cycles >= CYCLE_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	function automatic pair_t random_pair(bit near);
		pair_t p;
		p = pair_t'(PAIR_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom}));
		if (near) begin
			p.first_id = ID_W'($urandom_range(0, 7));
			p.second_id = ID_W'($urandom_range(0, 7));
			p.second_pos_x = POS_W'(p.first_pos_x + $signed($urandom_range(0, 4000)) - 2000);
			p.second_pos_y = POS_W'(p.first_pos_y + $signed($urandom_range(0, 4000)) - 2000);
			p.first_size_w = SIZE_W'($urandom_range(0, 40));
			p.first_size_h = SIZE_W'($urandom_range(0, 40));
			p.second_size_w = SIZE_W'($urandom_range(0, 40));
			p.second_size_h = SIZE_W'($urandom_range(0, 40));
		end
		return p;
	endfunction

	initial begin
		pair_t p;
		int s;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		// directed: each shape combination, enter/stay/exit, equal ids, extremes
		for (s = 0; s < 4; s++) begin
			p = '0;
			p.first_id = 1;
			p.second_id = 2;
			p.first_shape = s[1];
			p.second_shape = s[0];
			p.first_size_w = 4;
			p.first_size_h = 4;
			p.second_size_w = 4;
			p.second_size_h = 4;
			pending_pairs.push_back(p);
			pending_pairs.push_back(p);
			p.second_pos_x = 20'sh7FFFF;
			pending_pairs.push_back(p);
			pending_pairs.push_back(p);
		end
		p = '0;
		p.first_id = 5;
		p.second_id = 5;
		p.first_size_w = 16'hFFFF;
		pending_pairs.push_back(p);
		p = '1;
		p.first_id = 63;
		p.second_id = 0;
		p.first_pos_x = 20'sh80000;
		p.first_pos_y = 20'sh80000;
		pending_pairs.push_back(p);
		pending_pairs.push_back(p);
		p.second_id = 63;
		pending_pairs.push_back(p);
		p = '0;
		p.first_shape = SHAPE_CIRCLE;
		p.second_shape = SHAPE_CIRCLE;
		p.first_id = 62;
		p.second_id = 63;
		p.first_pos_x = 20'sh7FFFF;
		p.second_pos_x = 20'sh80000;
		p.first_size_w = 16'hFFFF;
		p.second_size_w = 16'hFFFF;
		pending_pairs.push_back(p);
		for (int i = 0; i < 265; i++) pending_pairs.push_back(random_pair($urandom_range(0, 9) < 8));
		wait (pending_pairs.size() == 0);
		hold_until_drained = 1'b1;
		for (int i = 0; i < 265; i++) pending_pairs.push_back(random_pair($urandom_range(0, 9) < 8));
		wait (pending_pairs.size() < 60);
		no_gaps = 1'b1;
		wait (pending_pairs.size() == 0);
		@(posedge clk);
		@(posedge clk);
		wait (expected_events.size() == 0);
		repeat (10) @(posedge clk);
		if (mismatches == 0 && expected_events.size() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end
endmodule
`default_nettype wire
